@@ rtl/core/cwcr_pkg.sv @@
package cwcr_pkg;

    localparam int SYM_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int CMD_W     = 5;
    localparam int ARG_W     = 10;
    localparam int LIM_W     = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 10;

    localparam int DEF_MAX_CMD_LEN = 4;
    localparam int PAT_LEN         = 4;
    localparam int NUM_CMDS        = 21;
    localparam int DEC_BASE        = 10;
    localparam int PAT_SYM_W       = 7;
    localparam int PAT_LEN_W       = 3;

    localparam logic [SYM_W-1:0]     SYM_LAST_DIGIT = 6'd9;
    localparam logic [SYM_W-1:0]     SYM_QM         = 6'd36;
    localparam logic [PAT_SYM_W-1:0] ANY_DIGIT      = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MAYBE   = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TX_DELAY_MIN     = 4'd0,
        REG_TX_DELAY_MAX     = 4'd1,
        REG_TX_OFF_DELAY_MIN = 4'd2,
        REG_TX_OFF_DELAY_MAX = 4'd3,
        REG_TONE_FREQ_MIN    = 4'd4,
        REG_TONE_FREQ_MAX    = 4'd5,
        REG_SPEED_MIN        = 4'd6,
        REG_SPEED_MAX        = 4'd7
    } cfg_reg_t;

    localparam logic [CMD_W-1:0] CMD_DNNN = 5'd1;
    localparam logic [CMD_W-1:0] CMD_ONN  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_TNNN = 5'd15;
    localparam logic [CMD_W-1:0] CMD_WNN  = 5'd20;

    typedef struct packed {
        logic [ARG_W-1:0] tx_delay_min;
        logic [ARG_W-1:0] tx_delay_max;
        logic [LIM_W-1:0] tx_off_delay_min;
        logic [LIM_W-1:0] tx_off_delay_max;
        logic [ARG_W-1:0] tone_freq_min;
        logic [ARG_W-1:0] tone_freq_max;
        logic [LIM_W-1:0] speed_min;
        logic [LIM_W-1:0] speed_max;
    } limits_t;

    localparam limits_t LIM_RESET = '{
        tx_delay_min:     10'd0,
        tx_delay_max:     10'd999,
        tx_off_delay_min: 7'd0,
        tx_off_delay_max: 7'd99,
        tone_freq_min:    10'd300,
        tone_freq_max:    10'd999,
        speed_min:        7'd5,
        speed_max:        7'd50
    };

    typedef logic [0:PAT_LEN-1][SYM_W-1:0] head_t;

    typedef struct packed {
        logic [PAT_LEN_W-1:0]                 len;
        logic [0:PAT_LEN-1][PAT_SYM_W-1:0]    sym;
    } pattern_t;

    typedef struct packed {
        status_t          status;
        logic [CMD_W-1:0] command;
        logic [ARG_W-1:0] argument;
    } match_res_t;

    // D? Dnnn IA IB IP M?1 M?2 M1 M2 O? Onn SWD SWE SK T? Tnnn TMD TME V? W? Wnn
    localparam pattern_t CMD_TABLE [NUM_CMDS] = '{
        '{3'd2, '{7'd13, 7'd36, 7'd0,  7'd0 }},
        '{3'd4, '{7'd13, 7'd64, 7'd64, 7'd64}},
        '{3'd2, '{7'd18, 7'd10, 7'd0,  7'd0 }},
        '{3'd2, '{7'd18, 7'd11, 7'd0,  7'd0 }},
        '{3'd2, '{7'd18, 7'd25, 7'd0,  7'd0 }},
        '{3'd3, '{7'd22, 7'd36, 7'd1,  7'd0 }},
        '{3'd3, '{7'd22, 7'd36, 7'd2,  7'd0 }},
        '{3'd2, '{7'd22, 7'd1,  7'd0,  7'd0 }},
        '{3'd2, '{7'd22, 7'd2,  7'd0,  7'd0 }},
        '{3'd2, '{7'd24, 7'd36, 7'd0,  7'd0 }},
        '{3'd3, '{7'd24, 7'd64, 7'd64, 7'd0 }},
        '{3'd3, '{7'd28, 7'd32, 7'd13, 7'd0 }},
        '{3'd3, '{7'd28, 7'd32, 7'd14, 7'd0 }},
        '{3'd2, '{7'd28, 7'd20, 7'd0,  7'd0 }},
        '{3'd2, '{7'd29, 7'd36, 7'd0,  7'd0 }},
        '{3'd4, '{7'd29, 7'd64, 7'd64, 7'd64}},
        '{3'd3, '{7'd29, 7'd22, 7'd13, 7'd0 }},
        '{3'd3, '{7'd29, 7'd22, 7'd14, 7'd0 }},
        '{3'd2, '{7'd31, 7'd36, 7'd0,  7'd0 }},
        '{3'd2, '{7'd32, 7'd36, 7'd0,  7'd0 }},
        '{3'd3, '{7'd32, 7'd64, 7'd64, 7'd0 }}
    };

endpackage

@@ rtl/core/cwcr_cfg_regs.sv @@
module cwcr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [cwcr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [cwcr_pkg::CFG_DAT_W-1:0] wr_data,
    output cwcr_pkg::limits_t              limits
);
    import cwcr_pkg::*;

    limits_t lim_reg;
    limits_t lim_next;

    always_comb
    begin
        lim_next = lim_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TX_DELAY_MIN:     lim_next.tx_delay_min     = wr_data[ARG_W-1:0];
                REG_TX_DELAY_MAX:     lim_next.tx_delay_max     = wr_data[ARG_W-1:0];
                REG_TX_OFF_DELAY_MIN: lim_next.tx_off_delay_min = wr_data[LIM_W-1:0];
                REG_TX_OFF_DELAY_MAX: lim_next.tx_off_delay_max = wr_data[LIM_W-1:0];
                REG_TONE_FREQ_MIN:    lim_next.tone_freq_min    = wr_data[ARG_W-1:0];
                REG_TONE_FREQ_MAX:    lim_next.tone_freq_max    = wr_data[ARG_W-1:0];
                REG_SPEED_MIN:        lim_next.speed_min        = wr_data[LIM_W-1:0];
                REG_SPEED_MAX:        lim_next.speed_max        = wr_data[LIM_W-1:0];
                default:              lim_next = lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= LIM_RESET;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign limits = lim_reg;

endmodule

@@ rtl/core/cwcr_match.sv @@
module cwcr_match #(
    parameter int MAX_CMD_LEN = cwcr_pkg::DEF_MAX_CMD_LEN,
    parameter int CNT_W       = $clog2(MAX_CMD_LEN + 1)
) (
    input  cwcr_pkg::head_t               head,
    input  logic [CNT_W-1:0]              count,
    input  logic [cwcr_pkg::SYM_W-1:0]    sym,
    input  cwcr_pkg::limits_t             limits,
    output cwcr_pkg::match_res_t          res
);
    import cwcr_pkg::*;

    localparam int CMP_W = (CNT_W > PAT_LEN_W) ? CNT_W : PAT_LEN_W;

    logic [SYM_W-1:0] cand [PAT_LEN];
    logic [CMP_W-1:0] len;
    logic             over_full;
    logic [NUM_CMDS-1:0] full;
    logic [NUM_CMDS-1:0] pre;
    logic [ARG_W-1:0]    num [NUM_CMDS];
    logic                found;
    logic [CMD_W-1:0]    idx;
    logic [ARG_W-1:0]    arg;
    logic                in_lim;

    // merge the new symbol into the buffered ones
    always_comb
    begin
        for (int k = 0; k < PAT_LEN; k++)
        begin
            cand[k] = (CNT_W'(k) == count) ? sym : head[k];
        end
        len       = CMP_W'(count) + CMP_W'(1);
        over_full = (count >= CNT_W'(MAX_CMD_LEN));
    end

    always_comb
    begin
        logic             hit;
        logic [ARG_W-1:0] n;
        logic [CMP_W-1:0] plen;
        for (int i = 0; i < NUM_CMDS; i++)
        begin
            hit  = 1'b1;
            n    = '0;
            plen = CMP_W'(CMD_TABLE[i].len);
            for (int k = 0; k < PAT_LEN; k++)
            begin
                if (CMP_W'(k) < len)
                begin
                    if (CMD_TABLE[i].sym[k] == ANY_DIGIT)
                    begin
                        if (cand[k] > SYM_LAST_DIGIT)
                        begin
                            hit = 1'b0;
                        end
                        n = ARG_W'(n * DEC_BASE + ARG_W'(cand[k]));
                    end
                    else if ({1'b0, cand[k]} != CMD_TABLE[i].sym[k])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            full[i] = hit && (len == plen);
            pre[i]  = hit && (len < plen);
            num[i]  = n;
        end
    end

    // first full match in table order wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = NUM_CMDS - 1; i >= 0; i--)
        begin
            if (full[i])
            begin
                found = 1'b1;
                idx   = CMD_W'(i);
            end
        end
        arg = num[idx];
    end

    always_comb
    begin
        case (idx)
            CMD_DNNN: in_lim = (arg >= limits.tx_delay_min) && (arg <= limits.tx_delay_max);
            CMD_ONN:  in_lim = (arg >= ARG_W'(limits.tx_off_delay_min))
                            && (arg <= ARG_W'(limits.tx_off_delay_max));
            CMD_TNNN: in_lim = (arg >= limits.tone_freq_min) && (arg <= limits.tone_freq_max);
            CMD_WNN:  in_lim = (arg >= ARG_W'(limits.speed_min))
                            && (arg <= ARG_W'(limits.speed_max));
            default:  in_lim = 1'b1;
        endcase
    end

    always_comb
    begin
        res.status   = ST_UNKNOWN;
        res.command  = '0;
        res.argument = '0;
        if (!over_full)
        begin
            if (found)
            begin
                if (in_lim)
                begin
                    res.status   = ST_OK;
                    res.command  = idx;
                    res.argument = arg;
                end
            end
            else if (|pre)
            begin
                res.status = ST_MAYBE;
            end
        end
    end

endmodule

@@ rtl/core/cw_command_recognizer_top.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_stall    symbol
// output    out_valid / out_stall  status, command, argument
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Symbol register, then result register; one request per cycle if out_stall is low.
// The symbol register feeds the table match, which updates the buffer and the result
// register in the same cycle. A stalled output holds the result; one more request
// waits in the symbol register before in_stall rises. Reset clears the buffer count
// and both valid flags and loads the default limits; cfg_ready is always high.
module cw_command_recognizer_top #(
    parameter int MAX_CMD_LEN = cwcr_pkg::DEF_MAX_CMD_LEN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cwcr_pkg::SYM_W-1:0]     symbol,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cwcr_pkg::STATUS_W-1:0]  status,
    output logic [cwcr_pkg::CMD_W-1:0]     command,
    output logic [cwcr_pkg::ARG_W-1:0]     argument,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cwcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwcr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import cwcr_pkg::*;

    localparam int CNT_W = $clog2(MAX_CMD_LEN + 1);
    localparam int IDX_W = $clog2(MAX_CMD_LEN);

    logic [SYM_W-1:0] sym_reg;
    logic             s1_vld_reg;
    logic             out_vld_reg;
    match_res_t       res_reg;
    logic [SYM_W-1:0] buf_reg [MAX_CMD_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic       adv;
    logic       fire;
    head_t      head;
    limits_t    limits;
    match_res_t res;

    assign cfg_ready = 1'b1;

    cwcr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .limits   (limits)
    );

    always_comb
    begin
        for (int k = 0; k < PAT_LEN; k++)
        begin
            head[k] = buf_reg[k];
        end
    end

    cwcr_match #(
        .MAX_CMD_LEN (MAX_CMD_LEN),
        .CNT_W       (CNT_W)
    ) u_match (
        .head   (head),
        .count  (count_reg),
        .sym    (sym_reg),
        .limits (limits),
        .res    (res)
    );

    assign adv      = !out_vld_reg || !out_stall;
    assign fire     = s1_vld_reg && adv;
    assign in_stall = s1_vld_reg && !adv;

    // keep the buffer only while a longer command may still follow
    assign count_next = (res.status == ST_MAYBE) ? CNT_W'(count_reg + 1'b1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (!s1_vld_reg || adv)
            begin
                s1_vld_reg <= in_valid;
            end
            if (adv)
            begin
                out_vld_reg <= s1_vld_reg;
            end
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sym_reg <= symbol;
        end
        if (fire)
        begin
            res_reg <= res;
            if (count_reg < CNT_W'(MAX_CMD_LEN))
            begin
                buf_reg[count_reg[IDX_W-1:0]] <= sym_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = res_reg.status;
    assign command   = res_reg.command;
    assign argument  = res_reg.argument;

endmodule
